[sv/qmn_pkg.sv]
// Shared types for the normalized quaternion product pipeline.
`timescale 1ns / 1ps

package qmn_pkg;

  // Advance enable and incoming valid for one pipeline section.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

[sv/qmn_isqrt.sv]
// Pipelined integer square root, one root bit resolved per register stage.
`timescale 1ns / 1ps

module qmn_isqrt #(
  parameter int ROOT_W = 33,
  parameter int SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qmn_pkg::pipe_ctl_t      ctl_i,
  input  logic [2*ROOT_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  output logic [ROOT_W-1:0]       root_o,
  output logic [SIDE_W-1:0]       side_o
);
  import qmn_pkg::*;

  logic                vld_q  [ROOT_W];
  logic [ROOT_W:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W];
  logic [SIDE_W-1:0]   side_q [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic                vld_in;
    logic [ROOT_W:0]     rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic [SIDE_W-1:0]   side_in;
    logic [ROOT_W+2:0]   cur;
    logic [ROOT_W+2:0]   trial;
    logic                fit;
    logic [ROOT_W:0]     rem_d;

    if (g == 0) begin : g_first
      assign vld_in  = ctl_i.valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign cur   = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign fit   = (cur >= trial);
    assign rem_d = fit ? (ROOT_W+1)'(cur - trial) : cur[ROOT_W:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= {root_in[ROOT_W-2:0], fit};
        rad_q[g]  <= rad_in << 2;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

[sv/quaternion_multiply_normalize_core.sv]
// Normalized Hamilton product of two fixed-point quaternions, fully pipelined.
// Throughput: one transaction per cycle while the output is not stalled; the
// depth is set by the square root (one stage per root bit) and the divider
// (one stage per quotient bit).
// Reset: asynchronous active low, clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps

module quaternion_multiply_normalize_core #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COMP_WIDTH-1:0] a_x_i,
  input  logic signed [COMP_WIDTH-1:0] a_y_i,
  input  logic signed [COMP_WIDTH-1:0] a_z_i,
  input  logic signed [COMP_WIDTH-1:0] a_w_i,
  input  logic signed [COMP_WIDTH-1:0] b_x_i,
  input  logic signed [COMP_WIDTH-1:0] b_y_i,
  input  logic signed [COMP_WIDTH-1:0] b_z_i,
  input  logic signed [COMP_WIDTH-1:0] b_w_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COMP_WIDTH-1:0] r_x_o,
  output logic signed [COMP_WIDTH-1:0] r_y_o,
  output logic signed [COMP_WIDTH-1:0] r_z_o,
  output logic signed [COMP_WIDTH-1:0] r_w_o,
  output logic                         zero_norm_o
);
  import qmn_pkg::*;

  localparam int W      = COMP_WIDTH;
  localparam int PW     = 2*W + 2;      // signed product component
  localparam int MW     = 2*W + 1;      // product magnitude
  localparam int NW     = 4*W + 1;      // squared norm
  localparam int KW     = 2*W + 1;      // square root
  localparam int RW     = 2*W + 2;      // divider remainder
  localparam int DS     = W - 1;        // quotient bits, one stage each
  localparam int SIDE_W = 4*MW + 5;

  localparam logic signed [W-1:0] ResLim = {2'b01, {(W-2){1'b0}}};

  // The whole pipe moves together; it holds only while a result waits.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: the sixteen component products.
  logic signed [W-1:0]   a_s [4];
  logic signed [W-1:0]   b_s [4];
  logic signed [2*W-1:0] m_d [16];
  logic signed [2*W-1:0] m_q [16];
  logic                  v1_q;

  assign a_s[0] = a_x_i;
  assign a_s[1] = a_y_i;
  assign a_s[2] = a_z_i;
  assign a_s[3] = a_w_i;
  assign b_s[0] = b_x_i;
  assign b_s[1] = b_y_i;
  assign b_s[2] = b_z_i;
  assign b_s[3] = b_w_i;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        m_d[4*i+j] = a_s[i] * b_s[j];
      end
    end
  end

  // Stage 2: Hamilton product sums, exact.
  logic signed [PW-1:0] p_d [4];
  logic signed [PW-1:0] p_q [4];
  logic                 v2_q;

  always_comb begin
    p_d[0] = PW'(m_q[12]) + PW'(m_q[3])  + PW'(m_q[6])  - PW'(m_q[9]);
    p_d[1] = PW'(m_q[13]) + PW'(m_q[7])  + PW'(m_q[8])  - PW'(m_q[2]);
    p_d[2] = PW'(m_q[14]) + PW'(m_q[11]) + PW'(m_q[1])  - PW'(m_q[4]);
    p_d[3] = PW'(m_q[15]) - PW'(m_q[0])  - PW'(m_q[5])  - PW'(m_q[10]);
  end

  // Stage 3: magnitude, sign and split partial products of each square.
  logic [MW-1:0]   mag_d  [4];
  logic [PW-1:0]   abs_d  [4];
  logic [3:0]      neg_d;
  logic            zero_d;
  logic [W:0]      hi_d   [4];
  logic [W-1:0]    lo_d   [4];
  logic [2*W+1:0]  hh_d   [4];
  logic [2*W:0]    hl_d   [4];
  logic [2*W-1:0]  ll_d   [4];
  logic [2*W+1:0]  hh_q   [4];
  logic [2*W:0]    hl_q   [4];
  logic [2*W-1:0]  ll_q   [4];
  logic [MW-1:0]   mag3_q [4];
  logic [3:0]      neg3_q;
  logic            zero3_q;
  logic            v3_q;

  always_comb begin
    zero_d = 1'b1;
    for (int c = 0; c < 4; c++) begin
      neg_d[c] = p_q[c][PW-1];
      abs_d[c] = neg_d[c] ? PW'(-p_q[c]) : PW'(p_q[c]);
      mag_d[c] = abs_d[c][MW-1:0];
      hi_d[c]  = mag_d[c][MW-1:W];
      lo_d[c]  = mag_d[c][W-1:0];
      hh_d[c]  = hi_d[c] * hi_d[c];
      hl_d[c]  = hi_d[c] * lo_d[c];
      ll_d[c]  = lo_d[c] * lo_d[c];
      if (p_q[c] != '0) begin
        zero_d = 1'b0;
      end
    end
  end

  // Stage 4: recombine the partials into each square.
  logic [NW-1:0] sq_d   [4];
  logic [NW-1:0] sq_q   [4];
  logic [MW-1:0] mag4_q [4];
  logic [3:0]    neg4_q;
  logic          zero4_q;
  logic          v4_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sq_d[c] = (NW'(hh_q[c]) << (2*W)) + (NW'(hl_q[c]) << (W+1)) + NW'(ll_q[c]);
    end
  end

  // Stage 5: squared norm.
  logic [NW-1:0] n_d;
  logic [NW-1:0] n_q;
  logic [MW-1:0] mag5_q [4];
  logic [3:0]    neg5_q;
  logic          zero5_q;
  logic          v5_q;

  assign n_d = sq_q[0] + sq_q[1] + sq_q[2] + sq_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q     <= m_d;
      p_q     <= p_d;
      hh_q    <= hh_d;
      hl_q    <= hl_d;
      ll_q    <= ll_d;
      mag3_q  <= mag_d;
      neg3_q  <= neg_d;
      zero3_q <= zero_d;
      sq_q    <= sq_d;
      mag4_q  <= mag3_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
      n_q     <= n_d;
      mag5_q  <= mag4_q;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
    end
  end

  // Square root section; magnitudes, signs and the zero flag ride along.
  pipe_ctl_t         sq_ctl;
  logic [SIDE_W-1:0] side_in;
  logic [SIDE_W-1:0] side_out;
  logic              rt_valid;
  logic [KW-1:0]     root;

  assign sq_ctl.en    = en;
  assign sq_ctl.valid = v5_q;
  assign side_in = {zero5_q, neg5_q, mag5_q[3], mag5_q[2], mag5_q[1], mag5_q[0]};

  qmn_isqrt #(
    .ROOT_W (KW),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sq_ctl),
    .rad_i   ({1'b0, n_q}),
    .side_i  (side_in),
    .valid_o (rt_valid),
    .root_o  (root),
    .side_o  (side_out)
  );

  // Restoring divider, one quotient bit per stage, four lanes sharing the root.
  logic          dv_q   [DS];
  logic [RW-1:0] dr_q   [DS][4];
  logic [DS-1:0] dq_q   [DS][4];
  logic [KW-1:0] ds_q   [DS];
  logic [3:0]    dneg_q [DS];
  logic          dzero_q[DS];

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic          v_in;
    logic [RW-1:0] r_in [4];
    logic [DS-1:0] q_in [4];
    logic [KW-1:0] s_in;
    logic [3:0]    neg_in;
    logic          zero_in;
    logic [RW-1:0] rr   [4];
    logic [RW-1:0] r_d  [4];
    logic [DS-1:0] q_d  [4];

    if (j == 0) begin : g_first
      assign v_in    = rt_valid;
      assign s_in    = root;
      assign neg_in  = side_out[4*MW +: 4];
      assign zero_in = side_out[4*MW+4];
      for (genvar c = 0; c < 4; c++) begin : g_lane
        assign r_in[c] = RW'(side_out[c*MW +: MW]);
        assign q_in[c] = '0;
        assign rr[c]   = r_in[c];
      end
    end else begin : g_next
      assign v_in    = dv_q[j-1];
      assign s_in    = ds_q[j-1];
      assign neg_in  = dneg_q[j-1];
      assign zero_in = dzero_q[j-1];
      for (genvar c = 0; c < 4; c++) begin : g_lane
        assign r_in[c] = dr_q[j-1][c];
        assign q_in[c] = dq_q[j-1][c];
        assign rr[c]   = r_in[c] << 1;
      end
    end

    // Subtract the root where it fits and shift the bit into the quotient.
    always_comb begin
      for (int c = 0; c < 4; c++) begin
        if (rr[c] >= RW'(s_in)) begin
          r_d[c] = rr[c] - RW'(s_in);
          q_d[c] = {q_in[c][DS-2:0], 1'b1};
        end else begin
          r_d[c] = rr[c];
          q_d[c] = {q_in[c][DS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en) begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dr_q[j]    <= r_d;
        dq_q[j]    <= q_d;
        ds_q[j]    <= s_in;
        dneg_q[j]  <= neg_in;
        dzero_q[j] <= zero_in;
      end
    end
  end

  // Output register: apply signs, force zero on a null product.
  logic [W-1:0] qx     [4];
  logic [W-1:0] res_d  [4];
  logic [W-1:0] res_q  [4];
  logic         zero_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      qx[c] = W'(dq_q[DS-1][c]);
      if (dzero_q[DS-1]) begin
        res_d[c] = '0;
      end else if (dneg_q[DS-1][c]) begin
        res_d[c] = W'(-qx[c]);
      end else begin
        res_d[c] = qx[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[DS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      zero_q <= dzero_q[DS-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign r_x_o       = $signed(res_q[0]);
  assign r_y_o       = $signed(res_q[1]);
  assign r_z_o       = $signed(res_q[2]);
  assign r_w_o       = $signed(res_q[3]);
  assign zero_norm_o = zero_q;

`ifndef SYNTHESIS
  a_zero_forces_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |->
      r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && r_w_o == '0)
    else $error("zero norm result carries nonzero component");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      r_x_o <= ResLim && r_x_o >= -ResLim && r_y_o <= ResLim && r_y_o >= -ResLim &&
      r_z_o <= ResLim && r_z_o >= -ResLim && r_w_o <= ResLim && r_w_o >= -ResLim)
    else $error("normalized component exceeds unit magnitude");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(out_valid_o) && $stable(r_w_o) && $stable(zero_norm_o))
    else $error("output moved while the pipe was held");
`endif

endmodule

[verif/tb_quaternion_multiply_normalize_core.sv]
// Self-checking testbench for the normalized quaternion product core.
`timescale 1ns / 1ps

module tb_quaternion_multiply_normalize_core;

  localparam int CW          = 16;
  localparam int LATENCY     = 3 * CW + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;
  localparam logic signed [CW-1:0] ONE_Q = 16'sd16384;
  localparam logic signed [CW-1:0] MAX_Q = 16'sh7fff;
  localparam logic signed [CW-1:0] MIN_Q = 16'sh8000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] w;
  } quat_t;

  typedef struct packed {
    quat_t unit_q;
    logic  zero_norm;
  } norm_prod_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [CW-1:0] a_x_i, a_y_i, a_z_i, a_w_i;
  logic signed [CW-1:0] b_x_i, b_y_i, b_z_i, b_w_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CW-1:0] r_x_o, r_y_o, r_z_o, r_w_o;
  logic zero_norm_o;

  norm_prod_t expected_prods[$];
  int unsigned mismatches       = 0;
  int unsigned products_checked = 0;
  int unsigned zero_norm_seen   = 0;
  int unsigned cycle_count      = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        rx_hold;

  quaternion_multiply_normalize_core #(.COMP_WIDTH(CW)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_x_i       (a_x_i),
    .a_y_i       (a_y_i),
    .a_z_i       (a_z_i),
    .a_w_i       (a_w_i),
    .b_x_i       (b_x_i),
    .b_y_i       (b_y_i),
    .b_z_i       (b_z_i),
    .b_w_i       (b_w_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .r_x_o       (r_x_o),
    .r_y_o       (r_y_o),
    .r_z_o       (r_z_o),
    .r_w_o       (r_w_o),
    .zero_norm_o (zero_norm_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Scale one product component by 2^14/root, truncating toward zero.
  function automatic logic signed [CW-1:0] scale_comp(longint p, logic [71:0] root);
    logic [71:0] mag;
    logic [71:0] q;
    mag = (p < 0) ? 72'(-p) : 72'(p);
    q   = (mag << (CW - 2)) / root;
    return (p < 0) ? CW'(-q) : CW'(q);
  endfunction

  // Hamilton product A*B, exact norm, floor square root, normalize.
  function automatic norm_prod_t normalized_product(quat_t a, quat_t b);
    longint      px, py, pz, pw;
    longint      m[4];
    logic [71:0] norm_sq;
    logic [71:0] root;
    logic [71:0] trial;
    norm_prod_t  res;
    px = longint'(a.w) * b.x + longint'(a.x) * b.w + longint'(a.y) * b.z - longint'(a.z) * b.y;
    py = longint'(a.w) * b.y + longint'(a.y) * b.w + longint'(a.z) * b.x - longint'(a.x) * b.z;
    pz = longint'(a.w) * b.z + longint'(a.z) * b.w + longint'(a.x) * b.y - longint'(a.y) * b.x;
    pw = longint'(a.w) * b.w - longint'(a.x) * b.x - longint'(a.y) * b.y - longint'(a.z) * b.z;
    m[0] = (px < 0) ? -px : px;
    m[1] = (py < 0) ? -py : py;
    m[2] = (pz < 0) ? -pz : pz;
    m[3] = (pw < 0) ? -pw : pw;
    norm_sq = '0;
    for (int k = 0; k < 4; k++) begin
      norm_sq += 72'(m[k]) * 72'(m[k]);
    end
    res = '0;
    if (norm_sq == '0) begin
      res.zero_norm = 1'b1;
      return res;
    end
    root = '0;
    for (int bit_idx = 2 * CW; bit_idx >= 0; bit_idx--) begin
      trial = root | (72'(1) << bit_idx);
      if (trial * trial <= norm_sq) root = trial;
    end
    res.unit_q.x = scale_comp(px, root);
    res.unit_q.y = scale_comp(py, root);
    res.unit_q.z = scale_comp(pz, root);
    res.unit_q.w = scale_comp(pw, root);
    return res;
  endfunction

  function automatic quat_t quat_of(int x, int y, int z, int w);
    quat_t q;
    q.x = CW'(x);
    q.y = CW'(y);
    q.z = CW'(z);
    q.w = CW'(w);
    return q;
  endfunction

  // Mostly full-range words, sometimes small or unit-scale ones, sometimes zero.
  function automatic quat_t random_quat();
    quat_t q;
    int unsigned kind;
    kind = $urandom_range(9);
    q = quat_t'({$urandom, $urandom});
    if (kind == 0) begin
      q = '0;
    end else if (kind < 3) begin
      q.x = CW'($signed($urandom_range(64)) - 32);
      q.y = CW'($signed($urandom_range(64)) - 32);
      q.z = CW'($signed($urandom_range(64)) - 32);
      q.w = CW'($signed($urandom_range(64)) - 32);
    end else if (kind < 5) begin
      q.x = CW'($signed($urandom_range(32768)) - 16384);
      q.y = CW'($signed($urandom_range(32768)) - 16384);
      q.z = CW'($signed($urandom_range(32768)) - 16384);
      q.w = CW'($signed($urandom_range(32768)) - 16384);
    end
    return q;
  endfunction

  // Maybe idle first, at the sender's idle rate, then offer one transaction and hold it until accepted.
  task automatic send_pair(quat_t a, quat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_x_i <= a.x; a_y_i <= a.y; a_z_i <= a.z; a_w_i <= a.w;
    b_x_i <= b.x; b_y_i <= b.y; b_z_i <= b.z; b_w_i <= b.w;
    do @(posedge clk_i); while (in_stall_o);
    expected_prods.push_back(normalized_product(a, b));
  endtask

  task automatic idle_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_prods.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    quat_t rnd;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_pair('0, '0);
    send_pair(quat_of(0, 0, 0, ONE_Q), quat_of(0, 0, 0, ONE_Q));
    send_pair(quat_of(ONE_Q, 0, 0, 0), quat_of(0, ONE_Q, 0, 0));
    send_pair(quat_of(0, ONE_Q, 0, 0), quat_of(0, 0, ONE_Q, 0));
    send_pair(quat_of(0, 0, ONE_Q, 0), quat_of(ONE_Q, 0, 0, 0));
    send_pair(quat_of(MAX_Q, MAX_Q, MAX_Q, MAX_Q), quat_of(MAX_Q, MAX_Q, MAX_Q, MAX_Q));
    send_pair(quat_of(MIN_Q, MIN_Q, MIN_Q, MIN_Q), quat_of(MIN_Q, MIN_Q, MIN_Q, MIN_Q));
    send_pair(quat_of(MIN_Q, MAX_Q, MIN_Q, MAX_Q), quat_of(MAX_Q, MIN_Q, MAX_Q, MIN_Q));
    send_pair(quat_of(MIN_Q, 0, 0, 0), quat_of(MIN_Q, 0, 0, 0));
    send_pair(quat_of(0, 0, 0, MIN_Q), quat_of(0, 0, 0, MAX_Q));
    send_pair(quat_of(1, 0, 0, 0), quat_of(0, 0, 0, 1));
    send_pair(quat_of(1, -1, 1, -1), quat_of(-1, -1, -1, -1));
    send_pair(quat_of(-1, -1, -1, -1), quat_of(-1, -1, -1, -1));
    send_pair(quat_of(MAX_Q, MAX_Q, MAX_Q, MAX_Q), '0);
    rnd = random_quat();
    send_pair('0, quat_of(MIN_Q, MIN_Q, MIN_Q, MIN_Q));
    send_pair(rnd, '0);
    send_pair(quat_of(3, 4, 0, 0), quat_of(0, 0, 0, 1));
    send_pair(quat_of(12, -5, 0, 0), quat_of(0, 0, 0, -1));
    send_pair(quat_of(-16383, 16383, -2, 7), quat_of(5, -3, 16384, -16384));
    idle_until_drained();
  endtask

  task automatic test_random(int unsigned count, int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_pair(random_quat(), random_quat());
    idle_until_drained();
  endtask

  // Hold the output while the sender keeps offering, so the pipeline backs up.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (3 * LATENCY) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      repeat (200) send_pair(random_quat(), random_quat());
    join
    idle_until_drained();
  endtask

  // Receiver: stall at the requested rate, or hold off entirely.
  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  // Check every accepted product against the oldest prediction.
  always @(posedge clk_i) begin
    norm_prod_t exp_p;
    norm_prod_t got_p;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_p.unit_q    = quat_of(r_x_o, r_y_o, r_z_o, r_w_o);
      got_p.zero_norm = zero_norm_o;
      if (expected_prods.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected product %h at cycle %0d", got_p, cycle_count);
      end else begin
        exp_p = expected_prods.pop_front();
        products_checked++;
        if (exp_p.zero_norm) zero_norm_seen++;
        if (got_p !== exp_p) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("ERROR: product mismatch exp x=%0d y=%0d z=%0d w=%0d zn=%0b",
                     exp_p.unit_q.x, exp_p.unit_q.y, exp_p.unit_q.z, exp_p.unit_q.w,
                     exp_p.zero_norm);
            $display("       got x=%0d y=%0d z=%0d w=%0d zn=%0b",
                     got_p.unit_q.x, got_p.unit_q.y, got_p.unit_q.z, got_p.unit_q.w,
                     got_p.zero_norm);
          end
        end
      end
    end
  end

  // Bound the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d products outstanding", expected_prods.size());
      $display("tb_quaternion_multiply_normalize_core NOT OK");
      $finish;
    end
  end

  initial begin
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    rx_hold          = 1'b0;
    in_valid_i       = 1'b0;
    {a_x_i, a_y_i, a_z_i, a_w_i, b_x_i, b_y_i, b_z_i, b_w_i} = '0;
    rst_ni           = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(330, 24, 74);
    test_random(330, 74, 24);
    test_backpressure();
    test_random(120, 0, 0);

    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Covered directed extremes, unit axes and zero products, random pairs under");
    $display("three idle mixes and a long output hold: %0d products checked, %0d zero-norm.",
             products_checked, zero_norm_seen);
    if (mismatches == 0 && expected_prods.size() == 0) begin
      $display("tb_quaternion_multiply_normalize_core OK");
    end else begin
      $display("ERROR: %0d mismatches, %0d products missing", mismatches, expected_prods.size());
      $display("tb_quaternion_multiply_normalize_core NOT OK");
    end
    $finish;
  end

endmodule
